// ===== sv/spk_pkg.sv =====
// Shared constants and types for the server picker.
package spk_pkg;
  localparam int NSRV = 16;
  localparam int SRV_W = 4;
  localparam int NSES = 64;
  localparam int SES_W = 6;
  localparam int KEY_BITS = 32;

  localparam logic [2:0] FUNC_WEIGHT = 3'd0;
  localparam logic [2:0] FUNC_REQ    = 3'd1;
  localparam logic [2:0] FUNC_HB     = 3'd2;
  localparam logic [2:0] FUNC_REPLY  = 3'd3;
  localparam logic [2:0] FUNC_SWEEP  = 3'd4;

  localparam logic [2:0] REG_COUNT   = 3'd0;
  localparam logic [2:0] REG_PICK    = 3'd1;
  localparam logic [2:0] REG_SMODE   = 3'd2;
  localparam logic [2:0] REG_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_MISS    = 3'd4;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [SRV_W-1:0]    srv;
    logic [31:0]         stamp;
  } ses_entry_t;
endpackage

// ===== sv/spk_ses_ram.sv =====
// Session table memory: one write port, one registered read port.
module spk_ses_ram import spk_pkg::*; (
  input  logic                 clk,
  input  logic                 we,
  input  logic [SES_W-1:0]     waddr,
  input  ses_entry_t           wdata,
  input  logic [SES_W-1:0]     raddr,
  output ses_entry_t           rdata
);
  ses_entry_t mem [NSES];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/server_picker_with_health_and_sessions.sv =====
// Top level of the server picker with health tracking and session affinity.
// channel  | direction | handshake              | payload
// config   | in        | psel/penable/pwrite    | paddr, pwdata, prdata
// item     | in        | start, busy            | func .. send_failed
// result   | out       | done (one-cycle strobe) | chosen_* .. expired_count
// A request with sessions on walks the session table at one read per cycle, then
// picks a server unless a live session hits; with sessions off it only picks. A
// sweep walks the servers, then the table if sessions are on; other events just end.
// done strobes in the first idle cycle after busy drops.
// The session table memory has one read port.
// rst is synchronous; session valid bits clear at once. Results cannot stall.
module server_picker_with_health_and_sessions import spk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [3:0]  server_index,
  input  logic [15:0] weight,
  input  logic [31:0] src_key,
  input  logic [31:0] usr_key,
  input  logic [15:0] rand_fraction,
  input  logic [31:0] now_seconds,
  input  logic [31:0] sent_seconds,
  input  logic        send_failed,
  output logic        done,
  output logic        chosen_valid,
  output logic [3:0]  chosen_server,
  output logic        session_hit,
  output logic        session_dropped,
  output logic [6:0]  expired_count
);
  localparam logic [3:0] S_IDLE = 4'd0, S_LOOK = 4'd1, S_TOT = 4'd2, S_PICK = 4'd3,
    S_WR = 4'd4, S_HLTH = 4'd5, S_EXP = 4'd6, S_OUT = 4'd7, S_FAST = 4'd8,
    S_RR = 4'd9;

  logic [3:0]  state;
  logic [4:0]  server_count;
  logic [1:0]  pick_mode, session_mode;
  logic [15:0] session_timeout;
  logic [7:0]  miss_limit;
  logic [15:0] wt [NSRV];
  logic [NSRV-1:0] healthy;
  logic [7:0]  misses [NSRV];
  logic [31:0] rtime [NSRV];
  logic [4:0]  last_choice;
  logic        last_none;
  logic [NSES-1:0] sval;

  logic [15:0] rq;
  logic [31:0] keyq, nowq;

  logic [6:0]  cnt;
  logic        rd_ok;
  logic [5:0]  rd_idx;
  logic        found, free_found;
  logic [5:0]  slot, free_slot;
  ses_entry_t  hit_e;
  logic [20:0] total, acc;
  logic        have, hit;
  logic [3:0]  pick;
  logic [31:0] best;
  logic [6:0]  removed;

  logic        ram_we;
  logic [5:0]  ram_wa, ram_ra;
  ses_entry_t  ram_wd, ram_rd;

  spk_ses_ram u_ram (.clk, .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
                     .raddr(ram_ra), .rdata(ram_rd));

  logic [4:0] n;
  assign n = (server_count > 5'd16) ? 5'd16 : server_count;
  assign pready = 1'b1;
  assign busy = (state != S_IDLE);
  assign ram_ra = cnt[5:0];

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_COUNT:   prdata = {27'd0, server_count};
      REG_PICK:    prdata = {30'd0, pick_mode};
      REG_SMODE:   prdata = {30'd0, session_mode};
      REG_TIMEOUT: prdata = {16'd0, session_timeout};
      REG_MISS:    prdata = {24'd0, miss_limit};
      default:     prdata = '0;
    endcase
  end

  logic sess_on;
  assign sess_on = !session_mode[1];

  // live hit: session server in use and healthy
  logic hit_live;
  assign hit_live = found && ({1'b0, hit_e.srv} < n) && healthy[hit_e.srv];

  logic [4:0] rr_start;
  logic [36:0] lhs, rhs;
  logic [3:0] ci;
  assign ci = cnt[3:0];
  assign lhs = {21'd0, rq} * {16'd0, total};
  assign rhs = {acc + {5'd0, wt[ci]}, 16'd0};

  always_ff @(posedge clk) begin
    ram_we <= 1'b0;
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      server_count <= '0;
      pick_mode <= 2'd2;
      session_mode <= 2'd2;
      session_timeout <= 16'd30;
      miss_limit <= 8'd4;
      healthy <= '1;
      for (int i = 0; i < NSRV; i++) begin
        wt[i] <= '0;
        misses[i] <= '0;
        rtime[i] <= '0;
      end
      last_choice <= '0;
      last_none <= 1'b1;
      sval <= '0;
      cnt <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[4:2])
          REG_COUNT: begin
            server_count <= pwdata[4:0];
            last_none <= (pwdata[4:0] == 5'd0);
            last_choice <= (pwdata[4:0] == 5'd0) ? 5'd0 :
                           ((pwdata[4:0] > 5'd16) ? 5'd15 : pwdata[4:0] - 5'd1);
          end
          REG_PICK:    pick_mode <= pwdata[1:0];
          REG_SMODE:   session_mode <= pwdata[1:0];
          REG_TIMEOUT: session_timeout <= pwdata[15:0];
          REG_MISS:    miss_limit <= pwdata[7:0];
          default: ;
        endcase
      end
      rd_ok <= 1'b0;
      rd_idx <= cnt[5:0];
      unique case (state)
        S_IDLE: if (start) begin
          rq <= rand_fraction;
          keyq <= (session_mode == 2'd0) ? src_key : usr_key;
          nowq <= now_seconds;
          chosen_valid <= 1'b0; chosen_server <= '0; session_hit <= 1'b0;
          session_dropped <= 1'b0; expired_count <= '0;
          cnt <= '0; found <= 1'b0; free_found <= 1'b0; removed <= '0;
          total <= '0; acc <= '0; have <= 1'b0; hit <= 1'b0; best <= '0;
          case (func)
            FUNC_WEIGHT: begin wt[server_index] <= weight; state <= S_OUT; end
            FUNC_HB: begin
              if ({1'b0, server_index} < n) begin
                if (send_failed) healthy[server_index] <= 1'b0;
                else if (misses[server_index] != 8'hFF)
                  misses[server_index] <= misses[server_index] + 8'd1;
              end
              state <= S_OUT;
            end
            FUNC_REPLY: begin
              if ({1'b0, server_index} < n) begin
                rtime[server_index] <= now_seconds - sent_seconds;
                misses[server_index] <= '0;
              end
              state <= S_OUT;
            end
            FUNC_REQ: state <= session_mode[1] ? S_TOT : S_LOOK;
            FUNC_SWEEP: state <= S_HLTH;
            default: state <= S_OUT;
          endcase
        end
        S_LOOK: begin
          // ram_rd holds entry rd_idx
          if (cnt <= 7'd63) begin rd_ok <= 1'b1; cnt <= cnt + 7'd1; end
          if (rd_ok) begin
            if (sval[rd_idx] && !found && ram_rd.key == keyq) begin
              found <= 1'b1; slot <= rd_idx; hit_e <= ram_rd;
            end
          end
          if (!sval[rd_idx] && !free_found && rd_ok) begin
            free_found <= 1'b1; free_slot <= rd_idx;
          end
          if (!rd_ok && cnt > 7'd1) begin
            cnt <= '0;
            state <= S_TOT;
          end
        end
        S_TOT: begin
          if (hit_live) begin
            hit <= 1'b1; have <= 1'b1; pick <= hit_e.srv;
            state <= S_WR;
          end else if (pick_mode == 2'd0) begin
            if ({2'd0, cnt} < {2'd0, 2'd0, n} && cnt < 7'd16) begin
              if (healthy[ci]) total <= total + {5'd0, wt[ci]};
              cnt <= cnt + 7'd1;
            end else begin
              cnt <= '0;
              state <= S_PICK;
            end
          end else if (pick_mode == 2'd1) begin
            state <= S_FAST;
          end else begin
            state <= S_RR;
          end
        end
        S_PICK: begin
          if (total == '0 || have || cnt >= {2'd0, n}) state <= S_WR;
          else begin
            if (healthy[ci]) begin
              acc <= acc + {5'd0, wt[ci]};
              if (lhs < rhs) begin have <= 1'b1; pick <= ci; end
            end
            cnt <= cnt + 7'd1;
          end
        end
        S_FAST: begin
          if (cnt >= {2'd0, n}) state <= S_WR;
          else begin
            if (healthy[ci] && (!have || rtime[ci] < best)) begin
              have <= 1'b1; pick <= ci; best <= rtime[ci];
            end
            cnt <= cnt + 7'd1;
          end
        end
        S_RR: begin
          if (have || cnt >= {2'd0, n}) state <= S_WR;
          else begin
            if (healthy[rr_start[3:0]]) begin have <= 1'b1; pick <= rr_start[3:0]; end
            cnt <= cnt + 7'd1;
          end
        end
        S_WR: begin
          last_none <= !have;
          last_choice <= have ? {1'b0, pick} : 5'd0;
          chosen_valid <= have;
          chosen_server <= have ? pick : 4'd0;
          session_hit <= hit;
          if (have && sess_on) begin
            if (found || free_found) begin
              ram_we <= 1'b1;
              ram_wa <= found ? slot : free_slot;
              ram_wd <= '{key: keyq, srv: pick, stamp: nowq};
              sval[found ? slot : free_slot] <= 1'b1;
            end else session_dropped <= 1'b1;
          end
          state <= S_OUT;
        end
        S_HLTH: begin
          if (cnt >= {2'd0, n}) begin
            cnt <= '0;
            state <= sess_on ? S_EXP : S_OUT;
          end else begin
            if (!healthy[ci] && misses[ci] < miss_limit) begin
              if (misses[ci] > miss_limit) healthy[ci] <= 1'b0;
              else healthy[ci] <= 1'b1;
            end else if (healthy[ci] && misses[ci] > miss_limit) healthy[ci] <= 1'b0;
            cnt <= cnt + 7'd1;
          end
        end
        S_EXP: begin
          if (cnt <= 7'd63) begin rd_ok <= 1'b1; cnt <= cnt + 7'd1; end
          if (rd_ok && sval[rd_idx] &&
              (nowq - ram_rd.stamp) >= {16'd0, session_timeout}) begin
            sval[rd_idx] <= 1'b0;
            removed <= removed + 7'd1;
          end
          if (!rd_ok && cnt > 7'd1) begin
            expired_count <= removed;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // round robin candidate: (start + cnt + 1) mod n
  logic [4:0] rr_base;
  logic [5:0] rr_sum;
  assign rr_base = (last_none || last_choice >= n) ? n - 5'd1 : last_choice;
  assign rr_sum = {1'b0, rr_base} + {1'b0, cnt[4:0]} + 6'd1;
  assign rr_start = (rr_sum >= {1'b0, n}) ? 5'(rr_sum - {1'b0, n}) : rr_sum[4:0];
endmodule

// ===== sv/spk_checker.sv =====
// Port-level checks for the server picker, bound to the top level.
module spk_checker import spk_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       chosen_valid,
  input logic [3:0] chosen_server,
  input logic       session_hit,
  input logic       session_dropped
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("start not taken");
  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy during result");
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    done && session_hit |-> chosen_valid) else $error("hit without choice");
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    done && !chosen_valid |-> chosen_server == 4'd0 && !session_dropped)
    else $error("bad empty result");
endmodule

bind server_picker_with_health_and_sessions spk_checker u_chk (.*);

// ===== bench/tb_server_picker_with_health_and_sessions.sv =====
// Self-checking testbench for the server picker with health tracking and sessions.
module tb_server_picker_with_health_and_sessions;
  import spk_pkg::*;

  typedef struct {
    logic [2:0]  func;
    logic [3:0]  sidx;
    logic [15:0] wgt;
    logic [31:0] src;
    logic [31:0] usr;
    logic [15:0] rnd;
    logic [31:0] now;
    logic [31:0] sent;
    logic        fail;
  } item_t;

  typedef struct {
    logic       cv;
    logic [3:0] cs;
    logic       hit;
    logic       drop;
    logic [6:0] expired;
  } pick_t;

  typedef struct {
    bit         is_cfg;
    logic [2:0] rsel;
    logic [31:0] val;
    item_t      it;
    bit         typed;
    pick_t      want;
  } row_t;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready, start = 0, busy, done;
  logic [2:0] func = '0;
  logic [3:0] server_index = '0;
  logic [15:0] weight = '0, rand_fraction = '0;
  logic [31:0] src_key = '0, usr_key = '0, now_seconds = '0, sent_seconds = '0;
  logic send_failed = 0;
  logic chosen_valid, session_hit, session_dropped;
  logic [3:0] chosen_server;
  logic [6:0] expired_count;

  server_picker_with_health_and_sessions dut (.*);

  always #4 clk = ~clk;

  // Predicted block state
  logic [4:0]  cnt_r;
  logic [1:0]  pmode_r, smode_r;
  logic [15:0] tmo_r;
  logic [7:0]  miss_r;
  logic [15:0] wt [NSRV];
  logic        healthy [NSRV];
  logic [7:0]  misses [NSRV];
  logic [31:0] reply_t [NSRV];
  logic [3:0]  last_pick;
  logic        last_none;
  logic        sv_valid [NSES];
  logic [31:0] sv_key [NSES];
  logic [3:0]  sv_srv [NSES];
  logic [31:0] sv_stamp [NSES];

  pick_t pending [$];
  int errors = 0;
  int idle_cycles = 0;
  logic [31:0] key_pool [8];
  logic [31:0] clock_s = 32'd1000;

  function automatic int used_n();
    return (cnt_r > NSRV) ? NSRV : cnt_r;
  endfunction

  function automatic void apply_cfg(logic [2:0] rsel, logic [31:0] v);
    case (rsel)
      REG_COUNT: begin
        cnt_r = v[4:0];
        last_none = (used_n() == 0);
        last_pick = last_none ? 4'd0 : 4'(used_n() - 1);
      end
      REG_PICK:    pmode_r = v[1:0];
      REG_SMODE:   smode_r = v[1:0];
      REG_TIMEOUT: tmo_r = v[15:0];
      REG_MISS:    miss_r = v[7:0];
      default: ;
    endcase
  endfunction

  // Choose a server by the current pick mode; returns 0 when none is eligible.
  function automatic bit choose_server(int n, logic [15:0] r, output logic [3:0] sel);
    longint unsigned total, acc;
    int strt, idx;
    logic [31:0] best;
    bit found;
    total = 0; acc = 0; found = 0; best = 0; sel = 0;
    if (pmode_r == 0) begin
      for (int i = 0; i < n; i++) if (healthy[i]) total += wt[i];
      if (total == 0) return 0;
      for (int i = 0; i < n; i++) begin
        if (!healthy[i]) continue;
        acc += wt[i];
        if (longint'(r) * total < acc * 65536) begin
          sel = 4'(i);
          return 1;
        end
      end
      return 0;
    end else if (pmode_r == 1) begin
      for (int i = 0; i < n; i++)
        if (healthy[i] && (!found || reply_t[i] < best)) begin
          best = reply_t[i]; sel = 4'(i); found = 1;
        end
      return found;
    end
    if (n == 0) return 0;
    strt = (last_none || last_pick >= n) ? n - 1 : last_pick;
    for (int k = 1; k <= n; k++) begin
      idx = (strt + k) % n;
      if (healthy[idx]) begin
        sel = 4'(idx);
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic pick_t predict_pick(item_t it);
    pick_t o;
    int n, slot, removed;
    bit sessions, found;
    logic [31:0] key;
    logic [3:0] sel;
    o = '{0, 0, 0, 0, 0};
    n = used_n();
    case (it.func)
      FUNC_WEIGHT: wt[it.sidx] = it.wgt;
      FUNC_REQ: begin
        sessions = smode_r < 2;
        key = (smode_r == 0) ? it.src : it.usr;
        found = 0; slot = 0;
        if (sessions)
          for (int i = 0; i < NSES; i++)
            if (sv_valid[i] && sv_key[i] == key) begin
              found = 1; slot = i; break;
            end
        if (found && sv_srv[slot] < n && healthy[sv_srv[slot]]) begin
          sv_stamp[slot] = it.now;
          last_pick = sv_srv[slot]; last_none = 0;
          o.cv = 1; o.cs = sv_srv[slot]; o.hit = 1;
        end else if (!choose_server(n, it.rnd, sel)) begin
          last_none = 1; last_pick = 0;
        end else begin
          last_pick = sel; last_none = 0;
          o.cv = 1; o.cs = sel;
          if (sessions) begin
            if (!found)
              for (int i = 0; i < NSES; i++)
                if (!sv_valid[i]) begin
                  found = 1; slot = i; break;
                end
            if (found) begin
              sv_valid[slot] = 1; sv_key[slot] = key;
              sv_srv[slot] = sel; sv_stamp[slot] = it.now;
            end else o.drop = 1;
          end
        end
      end
      FUNC_HB:
        if (it.sidx < n) begin
          if (it.fail) healthy[it.sidx] = 0;
          else if (misses[it.sidx] != 8'hFF) misses[it.sidx]++;
        end
      FUNC_REPLY:
        if (it.sidx < n) begin
          reply_t[it.sidx] = it.now - it.sent;
          misses[it.sidx] = 0;
        end
      FUNC_SWEEP: begin
        removed = 0;
        for (int i = 0; i < n; i++) begin
          if (!healthy[i] && misses[i] < miss_r) healthy[i] = 1;
          if (healthy[i] && misses[i] > miss_r) healthy[i] = 0;
        end
        if (smode_r < 2)
          for (int i = 0; i < NSES; i++)
            if (sv_valid[i] && (it.now - sv_stamp[i]) >= {16'd0, tmo_r}) begin
              sv_valid[i] = 0; removed++;
            end
        o.expired = (removed > 127) ? 7'd127 : 7'(removed);
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    pick_t w;
    if (!rst && done) begin
      if (pending.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        w = pending.pop_front();
        if (chosen_valid !== w.cv) report_mismatch("chosen_valid", chosen_valid, w.cv);
        if (chosen_server !== w.cs) report_mismatch("chosen_server", chosen_server, w.cs);
        if (session_hit !== w.hit) report_mismatch("session_hit", session_hit, w.hit);
        if (session_dropped !== w.drop)
          report_mismatch("session_dropped", session_dropped, w.drop);
        if (expired_count !== w.expired)
          report_mismatch("expired_count", expired_count, w.expired);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4000) begin
      $display("tb_server_picker_with_health_and_sessions: FAIL");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  // Called at a falling edge; hold the item until accepted, then idle for a random gap, which may be empty.
  task automatic send_item(item_t it, bit typed, pick_t want);
    pick_t p;
    int g;
    func = it.func; server_index = it.sidx; weight = it.wgt;
    src_key = it.src; usr_key = it.usr; rand_fraction = it.rnd;
    now_seconds = it.now; sent_seconds = it.sent; send_failed = it.fail;
    start = 1;
    do @(posedge clk); while (busy);
    p = predict_pick(it);
    pending = {pending, (typed ? want : p)};
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      start = 0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] rsel, logic [31:0] v);
    start = 0;
    while (pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    psel = 1; pwrite = 1; penable = 0; paddr = {rsel, 2'b00}; pwdata = v;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    apply_cfg(rsel, v);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  function automatic item_t rand_item(bit req_only);
    item_t it;
    int p;
    p = req_only ? 10 : $urandom_range(0, 99);
    clock_s += $urandom_range(0, 12);
    it.func = (p < 10) ? FUNC_WEIGHT : (p < 55) ? FUNC_REQ : (p < 70) ? FUNC_HB :
              (p < 80) ? FUNC_REPLY : (p < 95) ? FUNC_SWEEP : 3'($urandom_range(5, 7));
    it.sidx = 4'($urandom_range(0, 15));
    p = $urandom_range(0, 9);
    it.wgt = (p == 0) ? 16'd0 : (p < 3) ? 16'($urandom) : 16'($urandom_range(1, 50));
    it.src = req_only || $urandom_range(0, 3) == 0 ? $urandom : key_pool[$urandom_range(0, 7)];
    it.usr = $urandom_range(0, 3) == 0 ? $urandom : key_pool[$urandom_range(0, 7)];
    it.rnd = 16'($urandom);
    it.now = ($urandom_range(0, 24) == 0) ? $urandom : clock_s;
    it.sent = ($urandom_range(0, 9) == 0) ? $urandom : it.now - $urandom_range(0, 40);
    it.fail = ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  function automatic row_t cfg_row(logic [2:0] rsel, logic [31:0] v);
    row_t r;
    r = '{1, rsel, v, '{0, 0, 0, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, 0, 0}};
    return r;
  endfunction

  function automatic row_t it_row(logic [2:0] f, logic [3:0] s, logic [15:0] w,
      logic [31:0] sk, logic [31:0] uk, logic [15:0] r, logic [31:0] nw,
      logic [31:0] st, logic fl, bit typed, pick_t want);
    row_t x;
    x = '{0, 0, 0, '{f, s, w, sk, uk, r, nw, st, fl}, typed, want};
    return x;
  endfunction

  initial begin
    row_t tbl [$];
    pick_t z, p0;
    int n_items;
    z = '{0, 0, 0, 0, 0};
    p0 = '{1, 0, 0, 0, 0};
    foreach (key_pool[i]) key_pool[i] = $urandom;
    cnt_r = 0; pmode_r = 2; smode_r = 2; tmo_r = 30; miss_r = 4;
    last_none = 1; last_pick = 0;
    for (int i = 0; i < NSRV; i++) begin
      wt[i] = 0; healthy[i] = 1; misses[i] = 0; reply_t[i] = 0;
    end
    for (int i = 0; i < NSES; i++) begin
      sv_valid[i] = 0; sv_key[i] = 0; sv_srv[i] = 0; sv_stamp[i] = 0;
    end

    // no servers in use after reset: nothing to pick, nothing to sweep; undefined function codes give an empty result
    tbl = {tbl, it_row(FUNC_REQ, 0, 0, 1, 1, 0, 5, 0, 0, 1, z)};
    tbl = {tbl, it_row(FUNC_SWEEP, 0, 0, 0, 0, 0, 5, 0, 0, 1, z)};
    tbl = {tbl, it_row(3'd5, 4'hF, 16'hFFFF, '1, '1, '1, '1, '1, 1, 1, z)};
    tbl = {tbl, it_row(3'd6, 0, 0, 0, 0, 0, 0, 0, 0, 1, z)};
    tbl = {tbl, it_row(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 1, z)};
    tbl = {tbl, cfg_row(REG_COUNT, 16)};
    tbl = {tbl, cfg_row(REG_PICK, 2)};
    tbl = {tbl, cfg_row(REG_SMODE, 0)};
    tbl = {tbl, cfg_row(REG_TIMEOUT, 65535)};
    tbl = {tbl, cfg_row(REG_MISS, 255)};
    tbl = {tbl, it_row(FUNC_WEIGHT, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0, 1, z)};
    tbl = {tbl, it_row(FUNC_WEIGHT, 15, 16'h0000, 0, 0, 0, 0, 0, 0, 1, z)};
    tbl = {tbl, it_row(FUNC_WEIGHT, 7, 16'd300, 0, 0, 0, 0, 0, 0, 1, z)};
    // round robin from the last server wraps to server 0
    tbl = {tbl, it_row(FUNC_REQ, 0, 0, '1, 0, 0, 10, 0, 0, 1, p0)};
    tbl = {tbl, it_row(FUNC_REQ, 0, 0, '1, 0, 0, 11, 0, 0, 1, '{1, 0, 1, 0, 0})};
    tbl = {tbl, it_row(FUNC_HB, 0, 0, 0, 0, 0, 0, 0, 1, 1, z)};
    tbl = {tbl, it_row(FUNC_REQ, 0, 0, '1, 0, 0, 12, 0, 0, 0, z)};
    tbl = {tbl, it_row(FUNC_HB, 15, 0, 0, 0, 0, 0, 0, 0, 0, z)};
    tbl = {tbl, it_row(FUNC_REPLY, 3, 0, 0, 0, 0, 0, '1, 0, 0, z)};
    tbl = {tbl, it_row(FUNC_REPLY, 5, 0, 0, 0, 0, '1, 0, 0, 0, z)};
    tbl = {tbl, cfg_row(REG_PICK, 1)};
    tbl = {tbl, it_row(FUNC_REQ, 0, 0, 0, 0, 0, 13, 0, 0, 0, z)};
    tbl = {tbl, cfg_row(REG_PICK, 0)};
    tbl = {tbl, it_row(FUNC_REQ, 0, 0, 5, 0, 16'hFFFF, 14, 0, 0, 0, z)};
    tbl = {tbl, it_row(FUNC_REQ, 0, 0, 6, 0, 16'h0000, 15, 0, 0, 0, z)};
    tbl = {tbl, it_row(FUNC_SWEEP, 0, 0, 0, 0, 0, '1, 0, 0, 0, z)};
    tbl = {tbl, cfg_row(REG_TIMEOUT, 1)};
    tbl = {tbl, cfg_row(REG_MISS, 0)};
    tbl = {tbl, it_row(FUNC_SWEEP, 0, 0, 0, 0, 0, 20, 0, 0, 0, z)};
    tbl = {tbl, cfg_row(REG_SMODE, 1)};
    tbl = {tbl, it_row(FUNC_REQ, 0, 0, 0, '1, 0, 21, 0, 0, 0, z)};
    tbl = {tbl, it_row(FUNC_REQ, 0, 0, 0, '1, 0, 22, 0, 0, 0, z)};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;
    @(negedge clk);

    foreach (tbl[i])
      if (tbl[i].is_cfg) write_reg(tbl[i].rsel, tbl[i].val);
      else send_item(tbl[i].it, tbl[i].typed, tbl[i].want);

    // random phases, each with a fresh setting; the last one floods the session table
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(REG_COUNT, ph == 8 ? 16 : ph == 0 ? 16 : ph == 3 ? 31 : ph == 5 ? 0 :
                $urandom_range(1, 16));
      write_reg(REG_PICK, ph == 8 ? 2 : ph % 4);
      write_reg(REG_SMODE, ph == 8 ? 0 : (ph % 4 == 3) ? 2 + ph % 2 : ph % 2);
      write_reg(REG_TIMEOUT, (ph == 2 || ph == 8) ? 65535 : ph == 1 ? 1 :
                $urandom_range(1, 200));
      write_reg(REG_MISS, ph == 4 ? 0 : ph == 6 ? 255 : $urandom_range(0, 6));
      n_items = (ph == 8) ? 90 : 45;
      for (int k = 0; k < n_items; k++) send_item(rand_item(ph == 8), 0, z);
    end

    start = 0;
    while (pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) $display("tb_server_picker_with_health_and_sessions: PASS");
    else $display("tb_server_picker_with_health_and_sessions: FAIL");
    $finish;
  end
endmodule
